### sv/chv_pkg.sv
// ----------------------------------------------------------------------------
// chv_pkg
// Shared types, offsets, codes and lookup functions of the cartridge
// header validator.
// ----------------------------------------------------------------------------
package chv_pkg;

  localparam int unsigned FileSizeW = 24;
  localparam int unsigned OfsW      = 9;
  localparam int unsigned KibW      = 13;

  localparam logic [OfsW-1:0] OFS_LOGO_FIRST = 9'h104;
  localparam logic [OfsW-1:0] OFS_LOGO_LAST  = 9'h133;
  localparam logic [OfsW-1:0] OFS_SUM_FIRST  = 9'h134;
  localparam logic [OfsW-1:0] OFS_SUM_LAST   = 9'h14C;
  localparam logic [OfsW-1:0] OFS_TYPE       = 9'h147;
  localparam logic [OfsW-1:0] OFS_SIZE       = 9'h148;
  localparam logic [OfsW-1:0] OFS_RAM        = 9'h149;
  localparam logic [OfsW-1:0] OFS_REGION     = 9'h14A;
  localparam logic [OfsW-1:0] OFS_VERSION    = 9'h14C;
  localparam logic [OfsW-1:0] OFS_CHECK      = 9'h14D;

  localparam logic [FileSizeW-1:0] FILE_SIZE_RST = '0;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_LOGO     = 3'd1,
    ERR_SIZE     = 3'd2,
    ERR_TOO_BIG  = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    MAP_PLAIN   = 3'd0,
    MAP_MBC1    = 3'd1,
    MAP_MBC2    = 3'd2,
    MAP_MMM01   = 3'd3,
    MAP_MBC3    = 3'd4,
    MAP_MBC4    = 3'd5,
    MAP_MBC5    = 3'd6,
    MAP_UNKNOWN = 3'd7
  } mapper_t;

  localparam logic [2:0] RAM_UNKNOWN    = 3'd4;
  localparam logic [1:0] REGION_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [OfsW-1:0] byte_offset;
    logic [7:0]      byte_value;
  } in_t;

  typedef struct packed {
    logic            header_ok;
    logic [2:0]      error_code;
    logic [2:0]      mapper_kind;
    logic [KibW-1:0] rom_kib;
    logic [2:0]      ram_code;
    logic [1:0]      region_code;
    logic [7:0]      version_byte;
  } out_t;

  localparam logic [7:0] LOGO [48] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
    8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
    8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
    8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

  function automatic logic [KibW-1:0] kib_of(input logic [7:0] code);
    logic [KibW-1:0] kib;
    kib = '0;
    case (code)
      8'h00: kib = 13'd32;
      8'h01: kib = 13'd64;
      8'h02: kib = 13'd128;
      8'h03: kib = 13'd256;
      8'h04: kib = 13'd512;
      8'h05: kib = 13'd1024;
      8'h06: kib = 13'd2048;
      8'h07: kib = 13'd4096;
      8'h52: kib = 13'd1152;
      8'h53: kib = 13'd1280;
      8'h54: kib = 13'd1536;
      default: kib = '0;
    endcase
    return kib;
  endfunction

  function automatic mapper_t mapper_of(input logic [7:0] t);
    mapper_t m;
    m = MAP_UNKNOWN;
    case (t)
      8'h00, 8'h08, 8'h09:                      m = MAP_PLAIN;
      8'h01, 8'h02, 8'h03:                      m = MAP_MBC1;
      8'h05, 8'h06:                             m = MAP_MBC2;
      8'h0B, 8'h0C, 8'h0D:                      m = MAP_MMM01;
      8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        m = MAP_MBC3;
      8'h15, 8'h16, 8'h17:                      m = MAP_MBC4;
      8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: m = MAP_MBC5;
      default:                                  m = MAP_UNKNOWN;
    endcase
    return m;
  endfunction

endpackage

### sv/chv_hdr_track.sv
// ----------------------------------------------------------------------------
// chv_hdr_track
// Running header state: logo compare, checksum accumulation and captured
// fields; forms the verdict for the checksum byte and clears on it.
// ----------------------------------------------------------------------------
module chv_hdr_track
  import chv_pkg::*;
#(
  parameter int unsigned FILE_SIZE_W = FileSizeW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  in_t                    item,
  input  logic [FILE_SIZE_W-1:0] file_size,
  output logic                   is_check,
  output out_t                   verdict
);

  logic       logo_match_r, logo_match_nxt;
  logic [7:0] checksum_acc_r, checksum_acc_nxt;
  logic [7:0] cart_type_r, cart_type_nxt;
  logic [7:0] size_code_r, size_code_nxt;
  logic [7:0] ram_size_code_r, ram_size_code_nxt;
  logic [7:0] region_byte_r, region_byte_nxt;
  logic [7:0] version_reg_r, version_reg_nxt;

  logic            in_logo;
  logic            in_sum;
  logic [5:0]      logo_ofs;
  logic [KibW-1:0] kib;
  logic [KibW+9:0] rom_bytes;
  logic            too_big;
  err_t            err;

  assign in_logo   = (item.byte_offset >= OFS_LOGO_FIRST) && (item.byte_offset <= OFS_LOGO_LAST);
  assign in_sum    = (item.byte_offset >= OFS_SUM_FIRST) && (item.byte_offset <= OFS_SUM_LAST);
  assign is_check  = (item.byte_offset == OFS_CHECK);
  assign logo_ofs  = 6'(item.byte_offset - OFS_LOGO_FIRST);
  assign kib       = kib_of(size_code_r);
  assign rom_bytes = {kib, 10'b0};

  generate
    if (FILE_SIZE_W > KibW + 10) begin : g_wide
      assign too_big = FILE_SIZE_W'(rom_bytes) < file_size;
    end else begin : g_narrow
      assign too_big = rom_bytes < (KibW + 10)'(file_size);
    end
  endgenerate

  always_comb begin
    if (!logo_match_r) begin
      err = ERR_LOGO;
    end else if (kib == '0) begin
      err = ERR_SIZE;
    end else if (too_big) begin
      err = ERR_TOO_BIG;
    end else if (item.byte_value != checksum_acc_r) begin
      err = ERR_CHECKSUM;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    verdict.header_ok    = (err == ERR_OK);
    verdict.error_code   = err;
    verdict.mapper_kind  = mapper_of(cart_type_r);
    verdict.rom_kib      = kib;
    verdict.ram_code     = (ram_size_code_r > 8'd3) ? RAM_UNKNOWN : ram_size_code_r[2:0];
    verdict.region_code  = (region_byte_r > 8'd2) ? REGION_UNKNOWN : region_byte_r[1:0];
    verdict.version_byte = version_reg_r;
  end

  always_comb begin
    logo_match_nxt    = logo_match_r;
    checksum_acc_nxt  = checksum_acc_r;
    cart_type_nxt     = cart_type_r;
    size_code_nxt     = size_code_r;
    ram_size_code_nxt = ram_size_code_r;
    region_byte_nxt   = region_byte_r;
    version_reg_nxt   = version_reg_r;
    if (step) begin
      if (in_logo) begin
        if (LOGO[logo_ofs] != item.byte_value) begin
          logo_match_nxt = 1'b0;
        end
      end else if (in_sum) begin
        checksum_acc_nxt = checksum_acc_r - item.byte_value - 8'd1;
        case (item.byte_offset)
          OFS_TYPE:    cart_type_nxt     = item.byte_value;
          OFS_SIZE:    size_code_nxt     = item.byte_value;
          OFS_RAM:     ram_size_code_nxt = item.byte_value;
          OFS_REGION:  region_byte_nxt   = item.byte_value;
          OFS_VERSION: version_reg_nxt   = item.byte_value;
          default:     ;
        endcase
      end else if (is_check) begin
        logo_match_nxt    = 1'b1;
        checksum_acc_nxt  = '0;
        cart_type_nxt     = '0;
        size_code_nxt     = '0;
        ram_size_code_nxt = '0;
        region_byte_nxt   = '0;
        version_reg_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logo_match_r    <= 1'b1;
      checksum_acc_r  <= '0;
      cart_type_r     <= '0;
      size_code_r     <= '0;
      ram_size_code_r <= '0;
      region_byte_r   <= '0;
      version_reg_r   <= '0;
    end else begin
      logo_match_r    <= logo_match_nxt;
      checksum_acc_r  <= checksum_acc_nxt;
      cart_type_r     <= cart_type_nxt;
      size_code_r     <= size_code_nxt;
      ram_size_code_r <= ram_size_code_nxt;
      region_byte_r   <= region_byte_nxt;
      version_reg_r   <= version_reg_nxt;
    end
  end

endmodule

### sv/cartridge_header_validator.sv
// A verdict is registered when the checksum byte leaves the input register.
// Throughput: one byte per cycle while the result slot is free or drained;
// the single-pass update between input and result registers sets this rate.
// Reset (rst_n low, synchronous): pipeline empty, header state cleared,
// file_size 0.
// ----------------------------------------------------------------------------
// cartridge_header_validator
// Checks a cartridge image header streamed as offset-tagged bytes and
// emits one verdict per checksum byte.
// ----------------------------------------------------------------------------
module cartridge_header_validator
  import chv_pkg::*;
#(
  parameter int unsigned FILE_SIZE_W = FileSizeW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic [FILE_SIZE_W-1:0] cfg_wr_data
);

  logic                   s1_valid_r, s1_valid_nxt;
  in_t                    s1_r;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r;
  logic [FILE_SIZE_W-1:0] file_size_r;
  logic                   s1_adv;
  logic                   is_check;
  out_t                   verdict;

  // advance the held byte when the result slot is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && is_check) || (out_valid_r && !out_ready);

  chv_hdr_track #(
    .FILE_SIZE_W(FILE_SIZE_W)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .item     (s1_r),
    .file_size(file_size_r),
    .is_check (is_check),
    .verdict  (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      file_size_r <= FILE_SIZE_W'(FILE_SIZE_RST);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        file_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && is_check) begin
      out_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.header_ok == (out_r.error_code == ERR_OK)))
    else $error("header_ok disagrees with error_code");

  a_verdict_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && (s1_r.byte_offset == OFS_CHECK)))
    else $error("verdict without a checksum byte");

  a_hold_stalled_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("held byte lost while result slot busy");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.error_code <= ERR_CHECKSUM))
    else $error("error_code out of range");
`endif

endmodule

### tb/sv/cartridge_header_validator_test.sv
// ----------------------------------------------------------------------------
// cartridge_header_validator_test
// Streams offset-tagged image bytes into the header validator and checks
// every verdict, field by field, against a cycle-free model of the header
// state kept alongside the stimulus. Directed cases cover the ignored
// offsets, each error code and the clamped fields. Random whole headers,
// broken sequences and noise follow under idling and back-pressure on
// both channels, with the file size changed between phases.
// ----------------------------------------------------------------------------
module cartridge_header_validator_test;
  import chv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned RANDOM_ITEMS = 1600;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  in_t                  in_data     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  out_t                 out_data;
  logic                 cfg_wr_en   = 1'b0;
  logic [FileSizeW-1:0] cfg_wr_data = '0;

  // header state as the block should hold it
  logic                 hdr_logo_ok = 1'b1;
  logic [7:0]           hdr_sum     = '0;
  logic [7:0]           hdr_type    = '0;
  logic [7:0]           hdr_size    = '0;
  logic [7:0]           hdr_ram     = '0;
  logic [7:0]           hdr_region  = '0;
  logic [7:0]           hdr_version = '0;
  logic [FileSizeW-1:0] file_size_q = FILE_SIZE_RST;

  out_t        verdicts_due[$];
  int unsigned fail_count    = 0;
  int unsigned sent_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  logic        hold_start    = 1'b0;
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;

  cartridge_header_validator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on) begin
      out_ready <= ($urandom_range(99) >= 19);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic judge_header_byte(input in_t item);
    out_t            v;
    err_t            err;
    int unsigned     kib;
    logic [7:0]      t;
    logic [OfsW-1:0] lofs;
    if (item.byte_offset >= OFS_LOGO_FIRST && item.byte_offset <= OFS_LOGO_LAST) begin
      lofs = item.byte_offset - OFS_LOGO_FIRST;
      if (LOGO[lofs[5:0]] != item.byte_value) hdr_logo_ok = 1'b0;
    end else if (item.byte_offset >= OFS_SUM_FIRST && item.byte_offset <= OFS_SUM_LAST) begin
      hdr_sum = hdr_sum - item.byte_value - 8'd1;
      if (item.byte_offset == OFS_TYPE) hdr_type = item.byte_value;
      else if (item.byte_offset == OFS_SIZE) hdr_size = item.byte_value;
      else if (item.byte_offset == OFS_RAM) hdr_ram = item.byte_value;
      else if (item.byte_offset == OFS_REGION) hdr_region = item.byte_value;
      else if (item.byte_offset == OFS_VERSION) hdr_version = item.byte_value;
    end else if (item.byte_offset == OFS_CHECK) begin
      if (hdr_size <= 8'd7) kib = 32 << hdr_size;
      else if (hdr_size == 8'h52) kib = 1152;
      else if (hdr_size == 8'h53) kib = 1280;
      else if (hdr_size == 8'h54) kib = 1536;
      else kib = 0;

      if (!hdr_logo_ok) err = ERR_LOGO;
      else if (kib == 0) err = ERR_SIZE;
      else if ((kib << 10) < file_size_q) err = ERR_TOO_BIG;
      else if (item.byte_value != hdr_sum) err = ERR_CHECKSUM;
      else err = ERR_OK;

      t = hdr_type;
      if (t == 8'h00 || t == 8'h08 || t == 8'h09) v.mapper_kind = MAP_PLAIN;
      else if (t >= 8'h01 && t <= 8'h03) v.mapper_kind = MAP_MBC1;
      else if (t == 8'h05 || t == 8'h06) v.mapper_kind = MAP_MBC2;
      else if (t >= 8'h0B && t <= 8'h0D) v.mapper_kind = MAP_MMM01;
      else if (t >= 8'h0F && t <= 8'h13) v.mapper_kind = MAP_MBC3;
      else if (t >= 8'h15 && t <= 8'h17) v.mapper_kind = MAP_MBC4;
      else if (t >= 8'h19 && t <= 8'h1E) v.mapper_kind = MAP_MBC5;
      else v.mapper_kind = MAP_UNKNOWN;

      v.header_ok    = (err == ERR_OK);
      v.error_code   = err;
      v.rom_kib      = kib[KibW-1:0];
      v.ram_code     = (hdr_ram > 8'd3) ? RAM_UNKNOWN : hdr_ram[2:0];
      v.region_code  = (hdr_region > 8'd2) ? REGION_UNKNOWN : hdr_region[1:0];
      v.version_byte = hdr_version;
      verdicts_due.push_back(v);

      hdr_logo_ok = 1'b1;
      hdr_sum     = '0;
      hdr_type    = '0;
      hdr_size    = '0;
      hdr_ram     = '0;
      hdr_region  = '0;
      hdr_version = '0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none expected, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        check_field("header_ok", 32'(want.header_ok), 32'(out_data.header_ok));
        check_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
        check_field("mapper_kind", 32'(want.mapper_kind), 32'(out_data.mapper_kind));
        check_field("rom_kib", 32'(want.rom_kib), 32'(out_data.rom_kib));
        check_field("ram_code", 32'(want.ram_code), 32'(out_data.ram_code));
        check_field("region_code", 32'(want.region_code), 32'(out_data.region_code));
        check_field("version_byte", 32'(want.version_byte), 32'(out_data.version_byte));
      end
    end
  end

  task automatic send_byte(input logic [OfsW-1:0] ofs, input logic [7:0] val);
    in_t item;
    item.byte_offset = ofs;
    item.byte_value  = val;
    if (tx_idle_on) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    judge_header_byte(item);
    sent_count++;
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_file_size(input logic [FileSizeW-1:0] size);
    drain_verdicts();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    file_size_q = size;
  endtask

  task automatic test_empty_header();
    send_byte(OFS_CHECK, 8'h00);
    send_byte(OFS_CHECK, 8'hFF);
  endtask

  task automatic test_ignored_offsets();
    send_byte(9'h000, 8'h00);
    send_byte(9'h1FF, 8'hFF);
    send_byte(OFS_LOGO_FIRST - 9'd1, 8'hA5);
    send_byte(OFS_CHECK + 9'd1, 8'h5A);
  endtask

  task automatic test_logo_mismatch();
    send_byte(OFS_LOGO_FIRST, 8'h00);
    send_byte(OFS_CHECK, hdr_sum);
  endtask

  task automatic test_clamped_fields();
    send_byte(OFS_LOGO_LAST, LOGO[47]);
    send_byte(OFS_TYPE, 8'h1E);
    send_byte(OFS_SIZE, 8'h54);
    send_byte(OFS_RAM, 8'hFF);
    send_byte(OFS_REGION, 8'hFF);
    send_byte(OFS_VERSION, 8'hFF);
    send_byte(OFS_CHECK, hdr_sum);
  endtask

  task automatic test_illegal_size();
    send_byte(OFS_SIZE, 8'h08);
    send_byte(OFS_CHECK, hdr_sum);
  endtask

  task automatic test_repeated_offset();
    send_byte(OFS_SIZE, 8'h07);
    send_byte(OFS_SIZE, 8'h07);
    send_byte(OFS_CHECK, 8'h00);
  endtask

  task automatic test_file_too_large();
    set_file_size(24'd32769);
    send_byte(OFS_CHECK, hdr_sum);
    set_file_size(24'hFFFFFF);
    send_byte(OFS_SIZE, 8'h07);
    send_byte(OFS_CHECK, hdr_sum);
    set_file_size(24'd4194304);
    send_byte(OFS_SIZE, 8'h07);
    send_byte(OFS_CHECK, hdr_sum);
    set_file_size(24'd0);
  endtask

  task automatic test_back_pressure();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (40) begin
      send_byte(OFS_SIZE, 8'($urandom_range(255)));
      send_byte(OFS_CHECK, 8'($urandom_range(255)));
    end
    drain_verdicts();
  endtask

  task automatic send_random_header();
    logic [OfsW-1:0] ofs;
    logic [OfsW-1:0] lofs;
    logic [7:0]      val;
    int unsigned     bad_at;
    bad_at = ($urandom_range(9) == 0) ? $urandom_range(OFS_LOGO_LAST, OFS_LOGO_FIRST) : 0;
    for (ofs = OFS_LOGO_FIRST; ofs <= OFS_SUM_LAST; ofs++) begin
      if (ofs <= OFS_LOGO_LAST) begin
        lofs = ofs - OFS_LOGO_FIRST;
        val  = LOGO[lofs[5:0]];
      end else val = 8'($urandom_range(255));
      if (ofs == bad_at) val = val ^ (8'd1 << $urandom_range(7));
      case (ofs)
        OFS_TYPE:   val = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
        OFS_SIZE: begin
          case ($urandom_range(9))
            8:       val = 8'h52 + 8'($urandom_range(2));
            9:       val = 8'($urandom_range(255));
            default: val = 8'($urandom_range(7));
          endcase
        end
        OFS_RAM:    val = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom_range(255));
        OFS_REGION: val = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        default:    ;
      endcase
      if ($urandom_range(99) < 3) begin
        send_byte(9'h14E + 9'($urandom_range(177)), 8'($urandom_range(255)));
      end
      if ($urandom_range(99) >= 3) send_byte(ofs, val);
      if ($urandom_range(99) < 3) send_byte(ofs, val);
    end
    send_byte(OFS_CHECK, ($urandom_range(4) != 0) ? hdr_sum : 8'($urandom_range(255)));
  endtask

  task automatic send_broken_sequence();
    repeat ($urandom_range(16, 3)) send_byte(9'($urandom_range(OFS_CHECK, OFS_LOGO_FIRST)),
                                             8'($urandom_range(255)));
    send_byte(OFS_CHECK, $urandom_range(1) ? hdr_sum : 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(15, 5)) send_byte(9'($urandom_range(511)), 8'($urandom_range(255)));
  endtask

  task automatic test_random_headers();
    int unsigned items_from;
    int unsigned rounds;
    items_from = sent_count;
    rounds     = 0;
    while (sent_count < items_from + RANDOM_ITEMS) begin
      // hold both sides busy for the opening stretch
      tx_idle_on = (rounds >= 10);
      rx_idle_on = (rounds >= 10);
      if (rounds % 10 == 9) begin
        case ($urandom_range(3))
          0:       set_file_size(24'd0);
          1:       set_file_size(24'hFFFFFF);
          2:       set_file_size(24'($urandom_range(1 << 22)));
          default: set_file_size(24'((24'd32768 << $urandom_range(7)) + $urandom_range(1)));
        endcase
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: send_random_header();
        5, 6, 7:       send_broken_sequence();
        default:       send_noise();
      endcase
      rounds++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_header();
    test_ignored_offsets();
    test_logo_mismatch();
    test_clamped_fields();
    test_illegal_size();
    test_repeated_offset();
    test_file_too_large();
    test_back_pressure();
    test_random_headers();
    drain_verdicts();
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/chv_pkg.sv
sv/chv_hdr_track.sv
sv/cartridge_header_validator.sv
tb/sv/cartridge_header_validator_test.sv
